/* hdl/cll_pkg.sv */
// ----------------------------------------------------------------------------
// Command-line lexer package
// Shared types and constants for the lexer: parse modes, result kinds,
// line status codes, the lexer state record and the result record.
// ----------------------------------------------------------------------------
package cll_pkg;

   // Characters of interest.
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'd0,
      MODE_AFTER_GT = 3'd1,
      MODE_SKIP_OUT = 3'd2,
      MODE_SKIP_APP = 3'd3,
      MODE_SKIP_IN  = 3'd4,
      MODE_BODY_OUT = 3'd5,
      MODE_BODY_APP = 3'd6,
      MODE_BODY_IN  = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      KIND_ARG_CHAR    = 3'd0,
      KIND_OUT_CHAR    = 3'd1,
      KIND_APPEND_CHAR = 3'd2,
      KIND_IN_CHAR     = 3'd3,
      KIND_WORD_END    = 3'd4,
      KIND_LINE_END    = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_RUN         = 3'd0,
      STATUS_EMPTY       = 3'd1,
      STATUS_BAD_AMP     = 3'd2,
      STATUS_UNBALANCED  = 3'd3,
      STATUS_MANY_OUTS   = 3'd4,
      STATUS_MANY_INS    = 3'd5,
      STATUS_INPUT_ENDED = 3'd6
   } status_type;

   typedef struct packed {
      mode_type   mode;
      logic       quote_odd;
      logic       word_nonempty;
      logic [1:0] amp_level;
      logic [1:0] out_count;
      logic [1:0] append_count;
      logic [1:0] in_count;
      logic       any_word_seen;
      logic       last_was_name_add;
   } state_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] char_value;
      status_type status;
      logic       run_background;
      logic       has_out_file;
      logic       has_append_file;
      logic       has_in_file;
   } result_type;

   localparam state_type STATE_RESET = '{
      mode:              MODE_NORMAL,
      quote_odd:         1'b0,
      word_nonempty:     1'b0,
      amp_level:         2'd0,
      out_count:         2'd0,
      append_count:      2'd0,
      in_count:          2'd0,
      any_word_seen:     1'b0,
      last_was_name_add: 1'b0
   };

   // Counter that stops at two.
   function automatic logic [1:0] sat_inc(input logic [1:0] v);
      sat_inc = (v >= 2'd2) ? 2'd2 : v + 2'd1;
   endfunction

endpackage

/* hdl/command_line_lexer.sv */
// ----------------------------------------------------------------------------
// Command-line lexer
// Splits a stream of command-line characters into argument characters,
// redirection file name characters, word ends and line ends with status.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+---------------------------------
//   req_    | in        | req_valid/req_stall | in_char, end_of_input
//   rsp_    | out       | rsp_valid/rsp_stall | out_kind, char_value, line_status,
//           |           |                     | four line-end flags
//
// Each accepted item passes through an input register, then the step logic
// and the lexer state update into the result register. One item is taken
// every cycle while the result side does not stall. Items that cause no
// result simply advance the state. Reset is synchronous and clears the
// lexer state and both valid flags. A stall on the result side holds the
// result register and, through the input register, stalls the request
// side in the same cycle.
// ----------------------------------------------------------------------------
module command_line_lexer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_out_kind,
   output logic [7:0] rsp_char_value,
   output logic [2:0] rsp_line_status,
   output logic       rsp_run_background,
   output logic       rsp_has_out_file,
   output logic       rsp_has_append_file,
   output logic       rsp_has_in_file
);

   // Input register: holds one item ahead of the step logic.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;
   logic       in_eoi_ff, in_eoi_in;

   // Lexer state and the result register.
   cll_pkg::state_type  state_ff, state_in;
   cll_pkg::result_type rsp_ff, rsp_in;

   cll_pkg::state_type  step_state;
   cll_pkg::result_type step_result;

   logic advance;
   logic req_take;
   logic rsp_take;

   cll_step u_step (
      .cur_state    (state_ff),
      .in_char      (in_char_ff),
      .end_of_input (in_eoi_ff),
      .next_state   (step_state),
      .result       (step_result)
   );

   // The held item moves on when the result register is empty or is being
   // emptied in this cycle.
   assign rsp_take = rsp_ff.valid && !rsp_stall;
   assign advance  = in_valid_ff && (!rsp_ff.valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_eoi_in   = in_eoi_ff;
      state_in    = state_ff;
      rsp_in      = rsp_ff;

      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = step_state;
         rsp_in      = step_result;
      end else if (rsp_take) begin
         rsp_in.valid = 1'b0;
      end

      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_in_char;
         in_eoi_in   = req_end_of_input;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= cll_pkg::STATE_RESET;
         rsp_ff.valid <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      in_char_ff             <= in_char_in;
      in_eoi_ff              <= in_eoi_in;
      rsp_ff.kind            <= rsp_in.kind;
      rsp_ff.char_value      <= rsp_in.char_value;
      rsp_ff.status          <= rsp_in.status;
      rsp_ff.run_background  <= rsp_in.run_background;
      rsp_ff.has_out_file    <= rsp_in.has_out_file;
      rsp_ff.has_append_file <= rsp_in.has_append_file;
      rsp_ff.has_in_file     <= rsp_in.has_in_file;
   end

   assign rsp_valid           = rsp_ff.valid;
   assign rsp_out_kind        = 3'(rsp_ff.kind);
   assign rsp_char_value      = rsp_ff.char_value;
   assign rsp_line_status     = 3'(rsp_ff.status);
   assign rsp_run_background  = rsp_ff.run_background;
   assign rsp_has_out_file    = rsp_ff.has_out_file;
   assign rsp_has_append_file = rsp_ff.has_append_file;
   assign rsp_has_in_file     = rsp_ff.has_in_file;

   // The request side is only ever stalled by an item already held.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> in_valid_ff)
      else $error("request stalled with an empty input register");

   // A line end just produced leaves the lexer state back at reset.
   assert property (@(posedge clock) disable iff (reset)
      ($past(advance && !reset) && rsp_ff.valid && rsp_ff.kind == cll_pkg::KIND_LINE_END)
         |-> (state_ff == cll_pkg::STATE_RESET))
      else $error("line end did not return the lexer to its reset state");

   // An output name character just produced leaves the lexer in the name body.
   assert property (@(posedge clock) disable iff (reset)
      ($past(advance && !reset) && rsp_ff.valid && rsp_ff.kind == cll_pkg::KIND_OUT_CHAR)
         |-> (state_ff.mode == cll_pkg::MODE_BODY_OUT))
      else $error("output name character outside an output name");

   // Line status and flags are zero on every item other than a line end.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && rsp_ff.kind != cll_pkg::KIND_LINE_END)
         |-> (rsp_ff.status == cll_pkg::STATUS_RUN && !rsp_ff.run_background &&
              !rsp_ff.has_out_file && !rsp_ff.has_append_file && !rsp_ff.has_in_file))
      else $error("line-end fields set on an item that is not a line end");

endmodule

/* hdl/cll_step.sv */
// ----------------------------------------------------------------------------
// Command-line lexer step logic
// Combinational decision for one character: next lexer state and the
// result item, if any, that the character causes.
// ----------------------------------------------------------------------------
module cll_step (
   input  cll_pkg::state_type  cur_state,
   input  logic [7:0]          in_char,
   input  logic                end_of_input,
   output cll_pkg::state_type  next_state,
   output cll_pkg::result_type result
);

   always_comb begin
      cll_pkg::state_type s;
      cll_pkg::result_type r;
      logic done;
      logic nl;
      logic sp;

      s    = cur_state;
      r    = '0;
      done = 1'b0;
      nl   = !end_of_input && (in_char == cll_pkg::CHAR_NEWLINE);
      sp   = !end_of_input && (in_char == cll_pkg::CHAR_SPACE);

      // A single '>' waits one character to see whether it is '>>'.
      if (s.mode == cll_pkg::MODE_AFTER_GT) begin
         if (!end_of_input && in_char == cll_pkg::CHAR_GT) begin
            s.append_count = cll_pkg::sat_inc(s.append_count);
            s.mode         = cll_pkg::MODE_SKIP_APP;
            done           = 1'b1;
         end else begin
            s.out_count = cll_pkg::sat_inc(s.out_count);
            s.mode      = cll_pkg::MODE_SKIP_OUT;
         end
      end

      if (!done) begin
         unique case (s.mode)
            cll_pkg::MODE_SKIP_OUT, cll_pkg::MODE_SKIP_APP, cll_pkg::MODE_SKIP_IN: begin
               if (sp || (!end_of_input && (in_char == cll_pkg::CHAR_GT ||
                                            in_char == cll_pkg::CHAR_LT))) begin
                  done = 1'b1;
               end else if (end_of_input || nl) begin
                  s.mode = cll_pkg::MODE_NORMAL;
               end else begin
                  r.valid      = 1'b1;
                  r.char_value = in_char;
                  unique case (s.mode)
                     cll_pkg::MODE_SKIP_OUT: begin
                        r.kind = cll_pkg::KIND_OUT_CHAR;
                        s.mode = cll_pkg::MODE_BODY_OUT;
                     end
                     cll_pkg::MODE_SKIP_APP: begin
                        r.kind = cll_pkg::KIND_APPEND_CHAR;
                        s.mode = cll_pkg::MODE_BODY_APP;
                     end
                     default: begin
                        r.kind = cll_pkg::KIND_IN_CHAR;
                        s.mode = cll_pkg::MODE_BODY_IN;
                     end
                  endcase
                  s.last_was_name_add = 1'b1;
                  done                = 1'b1;
               end
            end
            cll_pkg::MODE_BODY_OUT, cll_pkg::MODE_BODY_APP, cll_pkg::MODE_BODY_IN: begin
               if (s.last_was_name_add && !end_of_input && in_char == cll_pkg::CHAR_AMP) begin
                  s.amp_level         = 2'd1;
                  s.last_was_name_add = 1'b0;
                  done                = 1'b1;
               end else if (end_of_input || nl || sp) begin
                  s.mode              = cll_pkg::MODE_NORMAL;
                  s.last_was_name_add = 1'b0;
               end else begin
                  r.valid      = 1'b1;
                  r.char_value = in_char;
                  unique case (s.mode)
                     cll_pkg::MODE_BODY_OUT: r.kind = cll_pkg::KIND_OUT_CHAR;
                     cll_pkg::MODE_BODY_APP: r.kind = cll_pkg::KIND_APPEND_CHAR;
                     default:                r.kind = cll_pkg::KIND_IN_CHAR;
                  endcase
                  s.last_was_name_add = 1'b1;
                  done                = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // Normal mode, also reached when a name or skip ends on this character.
      if (!done) begin
         priority if (end_of_input || nl) begin
            r.valid = 1'b1;
            r.kind  = cll_pkg::KIND_LINE_END;
            priority if (s.amp_level > 2'd1) begin
               r.status = cll_pkg::STATUS_BAD_AMP;
            end else if (s.quote_odd) begin
               r.status = cll_pkg::STATUS_UNBALANCED;
            end else if (s.out_count > 2'd1 || s.append_count > 2'd1) begin
               r.status = cll_pkg::STATUS_MANY_OUTS;
            end else if (s.in_count > 2'd1) begin
               r.status = cll_pkg::STATUS_MANY_INS;
            end else if (end_of_input) begin
               r.status = cll_pkg::STATUS_INPUT_ENDED;
            end else if (s.any_word_seen || s.word_nonempty) begin
               r.status = cll_pkg::STATUS_RUN;
            end else begin
               r.status = cll_pkg::STATUS_EMPTY;
            end
            r.run_background  = (s.amp_level == 2'd1);
            r.has_out_file    = (s.out_count == 2'd1);
            r.has_append_file = (s.append_count == 2'd1);
            r.has_in_file     = (s.in_count == 2'd1);
            s = cll_pkg::STATE_RESET;
         end else if (sp && !s.quote_odd) begin
            if (s.word_nonempty) begin
               r.valid         = 1'b1;
               r.kind          = cll_pkg::KIND_WORD_END;
               s.word_nonempty = 1'b0;
               s.any_word_seen = 1'b1;
            end
         end else if (in_char == cll_pkg::CHAR_QUOTE) begin
            s.quote_odd = !s.quote_odd;
         end else if (in_char == cll_pkg::CHAR_GT) begin
            s.mode = cll_pkg::MODE_AFTER_GT;
         end else if (in_char == cll_pkg::CHAR_LT) begin
            s.in_count = cll_pkg::sat_inc(s.in_count);
            s.mode     = cll_pkg::MODE_SKIP_IN;
         end else if (in_char == cll_pkg::CHAR_AMP) begin
            s.amp_level = cll_pkg::sat_inc(s.amp_level);
         end else begin
            if (s.amp_level > 2'd0) begin
               s.amp_level = 2'd2;
            end
            s.word_nonempty = 1'b1;
            r.valid         = 1'b1;
            r.kind          = cll_pkg::KIND_ARG_CHAR;
            r.char_value    = in_char;
         end
      end

      next_state = s;
      result     = r;
   end

endmodule
